// ===== rtl/rrqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types and constants of the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int BLOCK_SLOTS_DEF = 64;
   localparam int PID_WIDTH_DEF   = 16;

   localparam int OP_W       = 3;
   localparam int PID_PORT_W = 16;
   localparam int SLOT_PORT_W = 6;
   localparam int STATUS_W   = 2;
   localparam int LIVE_W     = 8;
   localparam int QUANTUM_W  = 16;
   localparam int TICKS_W    = 16;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic CSR_IDX_QUANTUM = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 3'd0,
      OP_BLOCK   = 3'd1,
      OP_UNBLOCK = 3'd2,
      OP_TERM    = 3'd3,
      OP_TICK    = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_IDLE = 2'd1,
      ST_WAIT = 2'd2,
      ST_REJ  = 2'd3
   } status_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_EXEC
   } seq_state_type;

endpackage

// ===== rtl/rrqs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rrqs_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rrqs_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqs_csr
// APB-style register file holding the scheduling quantum.
// ----------------------------------------------------------------------------
module rrqs_csr
   import rrqs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [CSR_DW-1:0]    csr_pwdata,
   output logic [CSR_DW-1:0]    csr_prdata,
   output logic                 csr_pready,
   output logic [QUANTUM_W-1:0] quantum
);

   logic [QUANTUM_W-1:0] quantum_ff;
   logic [QUANTUM_W-1:0] quantum_in;
   logic                 hit_quantum;

   assign hit_quantum = (csr_paddr[CSR_AW-1] == CSR_IDX_QUANTUM);

   always_comb begin
      quantum_in = quantum_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit_quantum) begin
         quantum_in = csr_pwdata[QUANTUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
      end else begin
         quantum_ff <= quantum_in;
      end
   end

   assign csr_prdata = hit_quantum ? CSR_DW'(quantum_ff) : '0;
   assign csr_pready = 1'b1;
   assign quantum    = quantum_ff;

endmodule

// ===== rtl/rrqs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqs_ctrl
// Read-modify-write sequencer: issues memory reads on accept, executes the
// opcode against the read data, writes back and registers the result beat.
// ----------------------------------------------------------------------------
module rrqs_ctrl
   import rrqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int BLOCK_SLOTS = BLOCK_SLOTS_DEF,
   parameter int PID_WIDTH   = PID_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [QUANTUM_W-1:0]           quantum,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [OP_W-1:0]                req_opcode,
   input  logic [PID_PORT_W-1:0]          req_pid,
   input  logic [SLOT_PORT_W-1:0]         req_slot,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic                           rsp_run_valid,
   output logic [PID_PORT_W-1:0]          rsp_run_pid,
   output logic [SLOT_PORT_W-1:0]         rsp_block_slot,
   output logic [LIVE_W-1:0]              rsp_live_count,
   output logic                           fifo_wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] fifo_wr_addr,
   output logic [PID_WIDTH-1:0]           fifo_wr_data,
   output logic                           fifo_rd_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] fifo_rd_addr,
   input  logic [PID_WIDTH-1:0]           fifo_rd_data,
   output logic                           tbl_wr_en,
   output logic [$clog2(BLOCK_SLOTS)-1:0] tbl_wr_addr,
   output logic [PID_WIDTH-1:0]           tbl_wr_data,
   output logic                           tbl_rd_en,
   output logic [$clog2(BLOCK_SLOTS)-1:0] tbl_rd_addr,
   input  logic [PID_WIDTH-1:0]           tbl_rd_data
);

   localparam int QA_W   = $clog2(QUEUE_DEPTH);
   localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOT_W = $clog2(BLOCK_SLOTS);
   localparam int BC_W   = $clog2(BLOCK_SLOTS + 1);
   localparam int SUM_W  = ((QC_W > BC_W) ? QC_W : BC_W) + 2;

   seq_state_type           state_ff, state_in;
   opcode_type              op_ff;
   logic [PID_WIDTH-1:0]    pid_ff;
   logic [SLOT_PORT_W-1:0]  slot_ff;

   logic [QA_W-1:0]         head_ff, head_in;
   logic [QA_W-1:0]         tail_ff, tail_in;
   logic [QC_W-1:0]         fcount_ff, fcount_in;
   logic                    run_valid_ff, run_valid_in;
   logic [PID_WIDTH-1:0]    run_pid_ff, run_pid_in;
   logic [TICKS_W-1:0]      ticks_ff, ticks_in;
   logic [BLOCK_SLOTS-1:0]  busy_ff, busy_in;
   logic [BC_W-1:0]         bcount_ff, bcount_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff, status_in;
   logic                    out_valid_ff;
   logic [PID_PORT_W-1:0]   out_pid_ff, out_pid_in;
   logic [SLOT_PORT_W-1:0]  bslot_ff, bslot_in;
   logic [LIVE_W-1:0]       live_ff, live_in;

   logic                    accept;
   logic                    fire;
   logic                    do_push;
   logic                    do_pop;
   logic [PID_WIDTH-1:0]    push_data;
   logic [BLOCK_SLOTS-1:0]  busy_plus;
   logic [BLOCK_SLOTS-1:0]  free_onehot;
   logic [SLOT_W-1:0]       free_idx;
   logic [SLOT_W-1:0]       slot_idx;
   logic                    slot_in_range;
   logic                    fifo_full;
   logic                    fifo_empty;
   logic                    slots_full;
   logic [SUM_W-1:0]        live_sum;

   assign req_ready = (state_ff == SEQ_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == SEQ_EXEC) && (!rsp_valid_ff || rsp_ready);

   // lowest free slot: lowest zero of the busy vector
   assign busy_plus   = busy_ff + BLOCK_SLOTS'(1);
   assign free_onehot = ~busy_ff & busy_plus;

   always_comb begin
      free_idx = '0;
      for (int i = 0; i < BLOCK_SLOTS; i++) begin
         if (free_onehot[i]) begin
            free_idx = free_idx | SLOT_W'(i);
         end
      end
   end

   assign slot_idx      = SLOT_W'(slot_ff);
   assign slot_in_range = (32'(slot_ff) < 32'(BLOCK_SLOTS));
   assign fifo_full     = (fcount_ff == QC_W'(QUEUE_DEPTH));
   assign fifo_empty    = (fcount_ff == '0);
   assign slots_full    = (bcount_ff == BC_W'(BLOCK_SLOTS));

   // memory reads are issued with the accept
   assign fifo_rd_en   = accept;
   assign fifo_rd_addr = head_ff;
   assign tbl_rd_en    = accept;
   assign tbl_rd_addr  = SLOT_W'(req_slot);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fcount_in    = fcount_ff;
      run_valid_in = run_valid_ff;
      run_pid_in   = run_pid_ff;
      ticks_in     = ticks_ff;
      busy_in      = busy_ff;
      bcount_in    = bcount_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = ST_OK;
      bslot_in     = '0;
      do_push      = 1'b0;
      do_pop       = 1'b0;
      push_data    = pid_ff;
      tbl_wr_en    = 1'b0;
      tbl_wr_addr  = free_idx;
      tbl_wr_data  = run_pid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               state_in = SEQ_EXEC;
            end
         end
         SEQ_EXEC: begin
            if (fire) begin
               state_in     = SEQ_IDLE;
               rsp_valid_in = 1'b1;
               case (op_ff)
                  OP_ADD: begin
                     if (fifo_full) begin
                        status_in = ST_REJ;
                     end else begin
                        do_push = 1'b1;
                     end
                  end
                  OP_BLOCK: begin
                     if (!run_valid_ff || slots_full) begin
                        status_in = ST_REJ;
                     end else begin
                        busy_in[free_idx] = 1'b1;
                        tbl_wr_en         = 1'b1;
                        bcount_in         = bcount_ff + BC_W'(1);
                        run_valid_in      = 1'b0;
                        ticks_in          = '0;
                        bslot_in          = SLOT_PORT_W'(free_idx);
                     end
                  end
                  OP_UNBLOCK: begin
                     if (!slot_in_range || !busy_ff[slot_idx] || fifo_full) begin
                        status_in = ST_REJ;
                     end else begin
                        do_push           = 1'b1;
                        push_data         = tbl_rd_data;
                        busy_in[slot_idx] = 1'b0;
                        bcount_in         = bcount_ff - BC_W'(1);
                     end
                  end
                  OP_TERM: begin
                     if (!run_valid_ff) begin
                        status_in = ST_REJ;
                     end else begin
                        run_valid_in = 1'b0;
                        ticks_in     = '0;
                     end
                  end
                  OP_TICK: begin
                     if (run_valid_ff) begin
                        if (ticks_ff >= quantum) begin
                           if (!fifo_empty) begin
                              do_pop     = 1'b1;
                              do_push    = 1'b1;
                              push_data  = run_pid_ff;
                              run_pid_in = fifo_rd_data;
                           end
                           ticks_in = TICKS_W'(1);
                        end else begin
                           ticks_in = ticks_ff + TICKS_W'(1);
                        end
                     end else if (!fifo_empty) begin
                        do_pop       = 1'b1;
                        run_pid_in   = fifo_rd_data;
                        run_valid_in = 1'b1;
                        ticks_in     = TICKS_W'(1);
                     end else if (bcount_ff != '0) begin
                        status_in = ST_WAIT;
                     end else begin
                        status_in = ST_IDLE;
                     end
                  end
                  default: begin
                     status_in = ST_REJ;
                  end
               endcase
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase

      if (do_pop) begin
         head_in = (head_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QA_W'(1);
      end
      if (do_push) begin
         tail_in = (tail_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QA_W'(1);
      end
      fcount_in = fcount_ff + QC_W'(do_push) - QC_W'(do_pop);
   end

   assign fifo_wr_en   = do_push;
   assign fifo_wr_addr = tail_ff;
   assign fifo_wr_data = push_data;

   assign live_sum = SUM_W'(fcount_in) + SUM_W'(bcount_in) + SUM_W'(run_valid_in);
   assign live_in  = LIVE_W'(live_sum);
   assign out_pid_in = run_valid_in ? PID_PORT_W'(run_pid_in) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fcount_ff    <= '0;
         run_valid_ff <= 1'b0;
         ticks_ff     <= '0;
         busy_ff      <= '0;
         bcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fcount_ff    <= fcount_in;
         run_valid_ff <= run_valid_in;
         ticks_ff     <= ticks_in;
         busy_ff      <= busy_in;
         bcount_ff    <= bcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_pid_ff <= run_pid_in;
      if (accept) begin
         op_ff   <= opcode_type'(req_opcode);
         pid_ff  <= PID_WIDTH'(req_pid);
         slot_ff <= req_slot;
      end
      if (fire) begin
         status_ff    <= status_in;
         out_valid_ff <= run_valid_in;
         out_pid_ff   <= out_pid_in;
         bslot_ff     <= bslot_in;
         live_ff      <= live_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_run_valid  = out_valid_ff;
   assign rsp_run_pid    = out_pid_ff;
   assign rsp_block_slot = bslot_ff;
   assign rsp_live_count = live_ff;

endmodule

// ===== rtl/round_robin_quantum_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_core
// Round-robin scheduler with a time quantum, ready queue and blocked table.
// ----------------------------------------------------------------------------
// Each request beat carries one opcode and produces exactly one response beat.
// An item has an accept and an execute cycle: the accept cycle reads the
// ready queue head and the addressed blocked-table entry from their RAMs,
// the execute cycle uses that read data, writes back and loads the response
// register. The next request is taken as soon as the execute cycle has run,
// even while the response still waits; a response that is not taken holds
// the execute cycle. Neither RAM is cleared after reset, so requests are
// taken right after reset. The quantum register is at csr byte addresses 0 to 3.
module round_robin_quantum_scheduler_core
   import rrqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int BLOCK_SLOTS = BLOCK_SLOTS_DEF,
   parameter int PID_WIDTH   = PID_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_AW-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]      csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OP_W-1:0]        req_opcode,
   input  logic [PID_PORT_W-1:0]  req_pid,
   input  logic [SLOT_PORT_W-1:0] req_slot,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic                   rsp_run_valid,
   output logic [PID_PORT_W-1:0]  rsp_run_pid,
   output logic [SLOT_PORT_W-1:0] rsp_block_slot,
   output logic [LIVE_W-1:0]      rsp_live_count
);

   localparam int QA_W   = $clog2(QUEUE_DEPTH);
   localparam int SLOT_W = $clog2(BLOCK_SLOTS);

   logic [QUANTUM_W-1:0] quantum;
   logic                 fifo_wr_en;
   logic [QA_W-1:0]      fifo_wr_addr;
   logic [PID_WIDTH-1:0] fifo_wr_data;
   logic                 fifo_rd_en;
   logic [QA_W-1:0]      fifo_rd_addr;
   logic [PID_WIDTH-1:0] fifo_rd_data;
   logic                 tbl_wr_en;
   logic [SLOT_W-1:0]    tbl_wr_addr;
   logic [PID_WIDTH-1:0] tbl_wr_data;
   logic                 tbl_rd_en;
   logic [SLOT_W-1:0]    tbl_rd_addr;
   logic [PID_WIDTH-1:0] tbl_rd_data;

   rrqs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .quantum     (quantum)
   );

   rrqs_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (PID_WIDTH)
   ) u_ready_ram (
      .clock   (clock),
      .wr_en   (fifo_wr_en),
      .wr_addr (fifo_wr_addr),
      .wr_data (fifo_wr_data),
      .rd_en   (fifo_rd_en),
      .rd_addr (fifo_rd_addr),
      .rd_data (fifo_rd_data)
   );

   rrqs_ram #(
      .DEPTH (BLOCK_SLOTS),
      .WIDTH (PID_WIDTH)
   ) u_blocked_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   rrqs_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .BLOCK_SLOTS (BLOCK_SLOTS),
      .PID_WIDTH   (PID_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .quantum        (quantum),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_pid        (req_pid),
      .req_slot       (req_slot),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_run_valid  (rsp_run_valid),
      .rsp_run_pid    (rsp_run_pid),
      .rsp_block_slot (rsp_block_slot),
      .rsp_live_count (rsp_live_count),
      .fifo_wr_en     (fifo_wr_en),
      .fifo_wr_addr   (fifo_wr_addr),
      .fifo_wr_data   (fifo_wr_data),
      .fifo_rd_en     (fifo_rd_en),
      .fifo_rd_addr   (fifo_rd_addr),
      .fifo_rd_data   (fifo_rd_data),
      .tbl_wr_en      (tbl_wr_en),
      .tbl_wr_addr    (tbl_wr_addr),
      .tbl_wr_data    (tbl_wr_data),
      .tbl_rd_en      (tbl_rd_en),
      .tbl_rd_addr    (tbl_rd_addr),
      .tbl_rd_data    (tbl_rd_data)
   );

endmodule

// ===== rtl/rrqs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqs_checker
// Port-level checks of the scheduler core, bound to the top level.
// ----------------------------------------------------------------------------
module rrqs_checker
   import rrqs_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_W-1:0]    rsp_status,
   input logic                   rsp_run_valid,
   input logic [PID_PORT_W-1:0]  rsp_run_pid,
   input logic [SLOT_PORT_W-1:0] rsp_block_slot,
   input logic [LIVE_W-1:0]      rsp_live_count
);

   // a stalled response beat stays valid and holds its status, run pid and live count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_run_pid) && $stable(rsp_live_count))
      else $error("response beat changed while stalled");

   a_pid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_valid |-> rsp_run_pid == '0)
      else $error("run pid nonzero with nothing running");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_block_slot == '0)
      else $error("block slot set on a non-ok beat");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_IDLE |-> !rsp_run_valid && rsp_live_count == '0)
      else $error("idle status with live processes");

   a_wait_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_WAIT |-> !rsp_run_valid)
      else $error("waiting status while a process runs");

endmodule

bind round_robin_quantum_scheduler_core rrqs_checker u_rrqs_checker (.*);
